### design/sfp_pkg.sv
// Shared constants for the short frame packetizer.
package sfp_pkg;

    localparam int DEFAULT_MAX_PAYLOAD = 6;

    localparam logic [7:0] FRAME_START = 8'h02;
    localparam logic [7:0] FRAME_KIND  = 8'h05;

    localparam int QUEUE_DEPTH = 2;

endpackage

### design/sfp_front.sv
// Front end: collects message bytes into a chunk and hands finished chunks to the queue.
module sfp_front
    import sfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD,
    parameter int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    parameter int LW = $clog2(MAX_PAYLOAD + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [7:0]               i_byte,
    input  logic                     i_last,
    output logic                     o_push,
    output logic [MAX_PAYLOAD*8-1:0] o_payload,
    output logic [LW-1:0]            o_len
);

    logic [7:0]    r_buf [MAX_PAYLOAD];
    logic [IW-1:0] r_fill;
    logic [IW-1:0] n_fill;
    logic          chunk_done;

    assign chunk_done = i_last || (r_fill == IW'(MAX_PAYLOAD - 1));
    assign o_push     = i_accept && chunk_done;
    assign o_len      = LW'(r_fill) + LW'(1);

    // Slots below the fill count come from the buffer, the new byte takes its
    // own slot, and every slot above it is sent as zero.
    always_comb begin
        for (int i = 0; i < MAX_PAYLOAD; i++) begin
            if (IW'(i) < r_fill) begin
                o_payload[i*8 +: 8] = r_buf[i];
            end else if (IW'(i) == r_fill) begin
                o_payload[i*8 +: 8] = i_byte;
            end else begin
                o_payload[i*8 +: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (i_accept) begin
            n_fill = chunk_done ? '0 : r_fill + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_buf[r_fill] <= i_byte;
        end
    end

endmodule

### design/sfp_queue.sv
// Two-entry chunk queue between the front end and the frame writer.
module sfp_queue
    import sfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD,
    parameter int LW = $clog2(MAX_PAYLOAD + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [MAX_PAYLOAD*8-1:0] i_payload,
    input  logic [LW-1:0]            i_len,
    output logic                     o_full,
    input  logic                     i_pop,
    output logic                     o_valid,
    output logic [MAX_PAYLOAD*8-1:0] o_payload,
    output logic [LW-1:0]            o_len
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [MAX_PAYLOAD*8-1:0] r_ent_pay [QUEUE_DEPTH];
    logic [LW-1:0]            r_ent_len [QUEUE_DEPTH];
    logic [PW-1:0]            r_wr_ptr;
    logic [PW-1:0]            r_rd_ptr;
    logic [CW-1:0]            r_count;

    assign o_full    = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_payload = r_ent_pay[r_rd_ptr];
    assign o_len     = r_ent_len[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent_pay[r_wr_ptr] <= i_payload;
            r_ent_len[r_wr_ptr] <= i_len;
        end
    end

endmodule

### design/sfp_back.sv
// Frame writer: turns one queued chunk into a frame, one byte per output request.
module sfp_back
    import sfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD,
    parameter int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    parameter int LW = $clog2(MAX_PAYLOAD + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  logic [MAX_PAYLOAD*8-1:0] i_q_payload,
    input  logic [LW-1:0]            i_q_len,
    output logic                     o_q_pop,
    output logic                     o_valid,
    output logic [7:0]               o_byte,
    output logic                     o_last,
    input  logic                     i_ready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_KIND  = 3'd1;
    localparam logic [2:0] ST_LEN   = 3'd2;
    localparam logic [2:0] ST_SLOT  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic [IW-1:0]            r_slot;
    logic [IW-1:0]            n_slot;
    logic [MAX_PAYLOAD*8-1:0] r_pay;
    logic [MAX_PAYLOAD*8-1:0] n_pay;
    logic [7:0]               r_len;
    logic [7:0]               n_len;
    logic [7:0]               r_check;
    logic [7:0]               n_check;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [7:0]               r_out_byte;
    logic [7:0]               n_out_byte;
    logic                     r_out_last;
    logic                     n_out_last;
    logic                     advance;

    assign advance = !r_out_valid || i_ready;
    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;
    assign o_q_pop = advance && (r_state == ST_IDLE) && i_q_valid;

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_pay       = r_pay;
        n_len       = r_len;
        n_check     = r_check;
        n_out_valid = r_out_valid && !i_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (advance) begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        n_pay       = i_q_payload;
                        n_len       = 8'(i_q_len);
                        n_check     = FRAME_KIND ^ 8'(i_q_len);
                        n_out_valid = 1'b1;
                        n_out_byte  = FRAME_START;
                        n_out_last  = 1'b0;
                        n_state     = ST_KIND;
                    end
                end
                ST_KIND: begin
                    n_out_valid = 1'b1;
                    n_out_byte  = FRAME_KIND;
                    n_out_last  = 1'b0;
                    n_state     = ST_LEN;
                end
                ST_LEN: begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_len;
                    n_out_last  = 1'b0;
                    n_slot      = '0;
                    n_state     = ST_SLOT;
                end
                ST_SLOT: begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_pay[7:0];
                    n_out_last  = 1'b0;
                    n_check     = r_check ^ r_pay[7:0];
                    n_pay       = r_pay >> 8;
                    n_slot      = r_slot + IW'(1);
                    if (r_slot == IW'(MAX_PAYLOAD - 1)) begin
                        n_state = ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_check;
                    n_out_last  = 1'b1;
                    n_state     = ST_IDLE;
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot     <= n_slot;
        r_pay      <= n_pay;
        r_len      <= n_len;
        r_check    <= n_check;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

endmodule

### design/short_frame_packetizer.sv
// A completing byte pushes its chunk into the queue, and the writer's output register
// then takes the frame's start byte. Throughput: one input byte per cycle while the
// two-entry chunk queue has room; the writer sends MAX_PAYLOAD + 4 bytes per chunk,
// one per cycle while the output is ready, which limits sustained full-chunk input.
// Reset (synchronous, active low) empties the chunk, the queue and the output register.
module short_frame_packetizer
    import sfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] frame_byte
    output logic       o_m_axis_tlast
);

    localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LW = $clog2(MAX_PAYLOAD + 1);

    logic                     in_accept;
    logic                     q_push;
    logic [MAX_PAYLOAD*8-1:0] q_in_payload;
    logic [LW-1:0]            q_in_len;
    logic                     q_full;
    logic                     q_pop;
    logic                     q_valid;
    logic [MAX_PAYLOAD*8-1:0] q_out_payload;
    logic [LW-1:0]            q_out_len;

    assign o_s_axis_tready = !q_full;
    assign in_accept       = i_s_axis_tvalid && !q_full;

    sfp_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD),
        .IW         (IW),
        .LW         (LW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_push   (q_push),
        .o_payload(q_in_payload),
        .o_len    (q_in_len)
    );

    sfp_queue #(
        .MAX_PAYLOAD(MAX_PAYLOAD),
        .LW         (LW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_payload(q_in_payload),
        .i_len    (q_in_len),
        .o_full   (q_full),
        .i_pop    (q_pop),
        .o_valid  (q_valid),
        .o_payload(q_out_payload),
        .o_len    (q_out_len)
    );

    sfp_back #(
        .MAX_PAYLOAD(MAX_PAYLOAD),
        .IW         (IW),
        .LW         (LW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_payload(q_out_payload),
        .i_q_len    (q_out_len),
        .o_q_pop    (q_pop),
        .o_valid    (o_m_axis_tvalid),
        .o_byte     (o_m_axis_tdata),
        .o_last     (o_m_axis_tlast),
        .i_ready    (i_m_axis_tready)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("chunk pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("chunk popped from an empty queue");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_in_len != '0) && (q_in_len <= LW'(MAX_PAYLOAD)))
        else $error("chunk length out of range");

endmodule

### verif/sfp_checker.sv
// Checker that predicts the frame bytes of the short frame packetizer and compares them.
module sfp_checker
    import sfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    input  logic       i_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tlast,
    input  logic       i_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    input  logic [7:0] i_m_axis_tdata,   // [7:0] frame_byte
    input  logic       i_m_axis_tlast,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_frame_beat;

    logic [7:0]  chunk_bytes [MAX_PAYLOAD];
    int          chunk_fill = 0;
    t_frame_beat frame_beat_q [$];
    t_frame_beat want_beat;
    int          fail_total = 0;

    task automatic report_error(input string msg);
        fail_total++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task automatic push_beat(input logic [7:0] value, input logic is_end);
        t_frame_beat beat;
        beat.frame_byte = value;
        beat.frame_end  = is_end;
        frame_beat_q.push_back(beat);
    endtask

    task automatic queue_frame();
        logic [7:0] length_byte;
        logic [7:0] slot;
        logic [7:0] check;
        length_byte = 8'(chunk_fill);
        check = FRAME_KIND ^ length_byte;
        push_beat(FRAME_START, 1'b0);
        push_beat(FRAME_KIND, 1'b0);
        push_beat(length_byte, 1'b0);
        for (int i = 0; i < MAX_PAYLOAD; i++) begin
            slot = (i < chunk_fill) ? chunk_bytes[i] : 8'h00;
            check ^= slot;
            push_beat(slot, 1'b0);
        end
        push_beat(check, 1'b1);
        chunk_fill = 0;
    endtask

    task automatic absorb_byte(input logic [7:0] data, input logic ends_message);
        if (chunk_fill >= MAX_PAYLOAD) begin
            chunk_fill = 0;
        end
        chunk_bytes[chunk_fill] = data;
        chunk_fill++;
        if (ends_message || chunk_fill >= MAX_PAYLOAD) begin
            queue_frame();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chunk_fill = 0;
            frame_beat_q.delete();
        end else begin
            // Compare before absorbing so a premature frame byte cannot match.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (frame_beat_q.size() == 0) begin
                    report_error($sformatf("frame byte %02h (end %0b) with none expected",
                                           i_m_axis_tdata, i_m_axis_tlast));
                end else begin
                    want_beat = frame_beat_q.pop_front();
                    if (i_m_axis_tdata !== want_beat.frame_byte) begin
                        report_error($sformatf("frame byte: expected %02h, got %02h",
                                               want_beat.frame_byte, i_m_axis_tdata));
                    end
                    if (i_m_axis_tlast !== want_beat.frame_end) begin
                        report_error($sformatf("frame end: expected %0b, got %0b",
                                               want_beat.frame_end, i_m_axis_tlast));
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                absorb_byte(i_s_axis_tdata, i_s_axis_tlast);
            end
        end
        o_pending    <= frame_beat_q.size();
        o_fail_count <= fail_total;
    end

endmodule

### verif/tb_short_frame_packetizer.sv
// Testbench top that drives message bytes into the short frame packetizer and gives the verdict.
module tb_short_frame_packetizer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN       = 20;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       in_tvalid  = 1'b0;
    logic       in_tready;
    logic [7:0] in_tdata   = 8'h00;
    logic       in_tlast   = 1'b0;
    logic       out_tvalid;
    logic       out_tready = 1'b0;
    logic [7:0] out_tdata;
    logic       out_tlast;

    int fail_count;
    int pending;
    int cycle_count    = 0;
    int bytes_sent     = 0;
    bit sender_idles   = 1'b1;
    bit quiet          = 1'b0;
    bit hold_request   = 1'b0;

    short_frame_packetizer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (in_tvalid),
        .o_s_axis_tready (in_tready),
        .i_s_axis_tdata  (in_tdata),
        .i_s_axis_tlast  (in_tlast),
        .o_m_axis_tvalid (out_tvalid),
        .i_m_axis_tready (out_tready),
        .o_m_axis_tdata  (out_tdata),
        .o_m_axis_tlast  (out_tlast)
    );

    sfp_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (in_tvalid),
        .i_s_axis_tready (in_tready),
        .i_s_axis_tdata  (in_tdata),
        .i_s_axis_tlast  (in_tlast),
        .i_m_axis_tvalid (out_tvalid),
        .i_m_axis_tready (out_tready),
        .i_m_axis_tdata  (out_tdata),
        .i_m_axis_tlast  (out_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("short_frame_packetizer test failed");
        $finish;
    end

    // Result side: random stalls, one long hold on request, none in the last part.
    initial begin
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            out_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic ends_message);
        if (sender_idles && !quiet && $urandom_range(0, 3) == 0) begin
            in_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_tvalid <= 1'b1;
        in_tdata  <= data;
        in_tlast  <= ends_message;
        @(posedge i_clk);
        while (!in_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_message(input int length);
        for (int i = 0; i < length; i++) begin
            send_byte(8'($urandom_range(0, 255)), i == length - 1);
        end
    endtask

    task automatic wait_for_frames();
        in_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-byte messages at both extremes.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // Message that ends exactly as the chunk fills.
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h08, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b1);
        // Full chunk without end mark, then a one-byte tail in a new chunk.
        send_byte(8'h40, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hFD, 1'b0);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'h55, 1'b1);
        // Short partial chunks with zero-filled slots.
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h0F, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h3C, 1'b1);

        wait_for_frames();

        // Receiver holds off while full chunks keep coming, so the input stalls.
        hold_request = 1'b1;
        sender_idles = 1'b0;
        send_message(12);
        send_message(9);
        sender_idles = 1'b1;

        while (bytes_sent < 85) begin
            send_message($urandom_range(1, 14));
        end

        quiet = 1'b1;
        while (bytes_sent < 110) begin
            send_message($urandom_range(1, 14));
        end

        wait_for_frames();
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("short_frame_packetizer test passed");
        end else begin
            $display("short_frame_packetizer test failed");
        end
        $finish;
    end

endmodule

### sim.f
design/sfp_pkg.sv
design/sfp_front.sv
design/sfp_queue.sv
design/sfp_back.sv
design/short_frame_packetizer.sv
verif/sfp_checker.sv
verif/tb_short_frame_packetizer.sv
